FILE: hdl/svm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svm_pkg: shared types and constants of the stereo voice mixer
// Opcodes, the command word of the shared multiply-accumulate unit and the
// fixed-point constants of the mix.
// ----------------------------------------------------------------------------
package svm_pkg;

    typedef enum logic [1:0] {
        OP_DEFINE = 2'd0,
        OP_WRITE  = 2'd1,
        OP_PLAY   = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    // command to the shared multiply-accumulate unit
    typedef struct packed {
        logic clear;     // zero both accumulators
        logic mul;       // load the product register from a * b
        logic to_left;   // add this product to the left accumulator next cycle
        logic to_right;  // add this product to the right accumulator next cycle
    } mac_cmd_t;

    localparam int          A_W       = 17;       // signed multiplier operand
    localparam int          B_W       = 30;       // unsigned multiplier operand
    localparam int          PROD_W    = A_W + B_W + 1;
    localparam int          FRAC_BITS = 30;       // accumulator LSB is 2^-30 output LSB
    localparam logic [29:0] GAIN_Q15  = 30'd23167; // 0.707 in Q15
    localparam logic [15:0] VOL_MAX   = 16'd32768; // 1.0 in Q1.15
    localparam logic [15:0] SAT_POS   = 16'h7FFF;
    localparam logic [15:0] SAT_NEG   = 16'h8000;

endpackage
`default_nettype wire

FILE: hdl/svm_sample_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svm_sample_ram: stereo sample frame store
// One write port and one registered read port; left in the low half.
// ----------------------------------------------------------------------------
module svm_sample_ram #(
    parameter int AW = 16,
    parameter int DW = 32
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold the last frame read until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: hdl/svm_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svm_mac: shared multiply-accumulate unit
// One registered multiplier feeding two stereo accumulators, with the
// truncate-and-saturate stage that turns an accumulator into a sample.
// ----------------------------------------------------------------------------
module svm_mac #(
    parameter int ACC_W = 54
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire svm_pkg::mac_cmd_t               cmd,
    input  wire logic signed [svm_pkg::A_W-1:0]  a,
    input  wire logic        [svm_pkg::B_W-1:0]  b,
    output logic signed [svm_pkg::PROD_W-1:0]    product,
    output logic        [15:0]                   sat_left,
    output logic        [15:0]                   sat_right
);

    logic signed [svm_pkg::PROD_W-1:0] prod_reg;
    logic                              pend_l_reg;
    logic                              pend_r_reg;
    logic signed [ACC_W-1:0]           acc_l_reg;
    logic signed [ACC_W-1:0]           acc_r_reg;
    logic signed [ACC_W-1:0]           prod_ext;

    // truncate toward zero by 2^-30, then clamp to 16 bits
    function automatic logic [15:0] finish(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] shifted;
        logic [15:0]      res;
        mag     = acc[ACC_W-1] ? (~acc + 1'b1) : acc;
        shifted = mag >> svm_pkg::FRAC_BITS;
        if (acc[ACC_W-1])
        begin
            res = (shifted > ACC_W'(32768)) ? svm_pkg::SAT_NEG : (~shifted[15:0] + 16'd1);
        end
        else
        begin
            res = (shifted > ACC_W'(32767)) ? svm_pkg::SAT_POS : shifted[15:0];
        end
        return res;
    endfunction

    assign prod_ext = {{(ACC_W - svm_pkg::PROD_W){prod_reg[svm_pkg::PROD_W-1]}}, prod_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= a * $signed({1'b0, b});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_l_reg <= 1'b0;
            pend_r_reg <= 1'b0;
            acc_l_reg  <= '0;
            acc_r_reg  <= '0;
        end
        else
        begin
            pend_l_reg <= cmd.mul & cmd.to_left;
            pend_r_reg <= cmd.mul & cmd.to_right;
            if (cmd.clear)
            begin
                acc_l_reg <= '0;
                acc_r_reg <= '0;
            end
            else
            begin
                if (pend_l_reg)
                begin
                    acc_l_reg <= acc_l_reg + prod_ext;
                end
                if (pend_r_reg)
                begin
                    acc_r_reg <= acc_r_reg + prod_ext;
                end
            end
        end
    end

    assign product   = prod_reg;
    assign sat_left  = finish(acc_l_reg);
    assign sat_right = finish(acc_r_reg);

endmodule
`default_nettype wire

FILE: hdl/stereo_voice_mixer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_voice_mixer: multi-voice one-shot stereo PCM mixer
// Sound slots point into a sample store; each slot owns one voice, and a
// tick mixes all active voices into one saturated stereo frame.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Payload
//  --------  -----------------  ----------------------------------------------
//  command   start, busy        opcode, sound_id, address, length,
//                               sample_left, sample_right, volume
//  result    done (strobe)      out_left, out_right, active_voices
//
//  A command word is taken at a rising edge with start high and busy low.
//  Define and write leave busy low. Play holds busy while the shared
//  multiplier forms volume * 0.707 as the voice weight.
//  A tick keeps busy high while it scans each slot, runs two multiplies per
//  active voice on the one shared multiplier, drains the accumulator and
//  saturates the result. done is high for exactly one cycle after that; the
//  receiver cannot stall, and a new command may be taken in that same cycle.
//  Reset clears slot lengths, voice flags and positions; the sample store and
//  slot starts hold nothing defined until written. SAMPLE_DEPTH is a power of
//  two, and addresses wrap modulo it.
// ----------------------------------------------------------------------------
module stereo_voice_mixer #(
    parameter int NUM_SOUNDS   = 32,
    parameter int SAMPLE_DEPTH = 65536
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         opcode,
    input  wire logic [4:0]         sound_id,
    input  wire logic [15:0]        address,
    input  wire logic [16:0]        length,
    input  wire logic signed [15:0] sample_left,
    input  wire logic signed [15:0] sample_right,
    input  wire logic [15:0]        volume,
    output logic                    done,
    output logic signed [15:0]      out_left,
    output logic signed [15:0]      out_right,
    output logic [5:0]              active_voices
);

    localparam int IDX_W    = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1;
    localparam int ID_EXT_W = (IDX_W > 5) ? IDX_W : 5;
    localparam int AW       = $clog2(SAMPLE_DEPTH);
    localparam int WA_W     = (AW > 16) ? AW : 16;
    localparam int RA_W     = (AW > 18) ? AW : 18;
    localparam int ACC_W    = svm_pkg::PROD_W + $clog2(NUM_SOUNDS) + 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PLAYW = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_MULL  = 7'b0001000,
        S_MULR  = 7'b0010000,
        S_FLUSH = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    // sequencer
    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] k_next;
    logic [5:0]       count_reg;
    logic [5:0]       count_next;

    // slot descriptors and voice state
    logic [15:0]      sound_start_reg  [NUM_SOUNDS];
    logic [16:0]      sound_length_reg [NUM_SOUNDS];
    logic [16:0]      voice_pos_reg    [NUM_SOUNDS];
    logic [svm_pkg::B_W-1:0] voice_weight_reg [NUM_SOUNDS];
    logic [NUM_SOUNDS-1:0]   voice_active_reg;

    // result registers
    logic             done_reg;
    logic [15:0]      out_left_reg;
    logic [15:0]      out_right_reg;
    logic [5:0]       active_voices_reg;

    // command decode
    logic                accept;
    logic                id_ok;
    logic [ID_EXT_W-1:0] id_ext;
    logic [IDX_W-1:0]    id_idx;
    logic [IDX_W-1:0]    rd_idx;
    logic                play_go;
    logic                tick_go;
    logic [15:0]         vol_sat;
    logic                last_k;

    // voice step
    logic [16:0]      pos_inc;
    logic             voice_stop;
    logic [RA_W-1:0]  ra_sum;
    logic [WA_W-1:0]  wa_ext;
    logic             ram_re;
    logic [31:0]      ram_rdata;

    // shared unit
    svm_pkg::mac_cmd_t                 mac_cmd;
    logic signed [svm_pkg::A_W-1:0]    mac_a;
    logic        [svm_pkg::B_W-1:0]    mac_b;
    logic signed [svm_pkg::PROD_W-1:0] mac_product;
    logic        [15:0]                mac_left;
    logic        [15:0]                mac_right;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start & ~busy;
    assign id_ok  = (32'(sound_id) < NUM_SOUNDS);
    assign id_ext = ID_EXT_W'(sound_id);
    assign id_idx = id_ext[IDX_W-1:0];

    // one slot read index: the command's slot while idle, the scan slot after
    assign rd_idx = (state_reg == S_IDLE) ? id_idx : k_reg;

    assign play_go = accept && (opcode == svm_pkg::OP_PLAY) && id_ok
                     && (sound_length_reg[rd_idx] != 17'd0);
    assign tick_go = accept && (opcode == svm_pkg::OP_TICK);
    assign vol_sat = (volume > svm_pkg::VOL_MAX) ? svm_pkg::VOL_MAX : volume;
    assign last_k  = (k_reg == IDX_W'(NUM_SOUNDS - 1));

    // advance the voice; stop it past its length or on position wrap
    assign pos_inc    = voice_pos_reg[rd_idx] + 17'd1;
    assign voice_stop = (pos_inc >= sound_length_reg[rd_idx]) || (pos_inc == 17'd0);
    assign ra_sum     = RA_W'(sound_start_reg[rd_idx]) + RA_W'(voice_pos_reg[rd_idx]);
    assign wa_ext     = WA_W'(address);
    assign ram_re     = (state_reg == S_SCAN) && voice_active_reg[rd_idx];

    svm_sample_ram #(
        .AW (AW),
        .DW (32)
    ) u_ram (
        .clk   (clk),
        .we    (accept && (opcode == svm_pkg::OP_WRITE)),
        .waddr (wa_ext[AW-1:0]),
        .wdata ({sample_right, sample_left}),
        .re    (ram_re),
        .raddr (ra_sum[AW-1:0]),
        .rdata (ram_rdata)
    );

    // drive the shared multiplier: clear at tick, weight at play, left then right per voice
    always_comb
    begin
        mac_cmd = '0;
        mac_a   = '0;
        mac_b   = '0;
        case (state_reg)
            S_IDLE:
            begin
                mac_cmd.clear = tick_go;
                mac_cmd.mul   = play_go;
                mac_a         = $signed({1'b0, vol_sat});
                mac_b         = svm_pkg::GAIN_Q15;
            end
            S_MULL:
            begin
                mac_cmd.mul     = 1'b1;
                mac_cmd.to_left = 1'b1;
                mac_a           = $signed({ram_rdata[15], ram_rdata[15:0]});
                mac_b           = voice_weight_reg[rd_idx];
            end
            S_MULR:
            begin
                mac_cmd.mul      = 1'b1;
                mac_cmd.to_right = 1'b1;
                mac_a            = $signed({ram_rdata[31], ram_rdata[31:16]});
                mac_b            = voice_weight_reg[rd_idx];
            end
            default:
            begin
                mac_cmd = '0;
            end
        endcase
    end

    svm_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (mac_cmd),
        .a         (mac_a),
        .b         (mac_b),
        .product   (mac_product),
        .sat_left  (mac_left),
        .sat_right (mac_right)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        count_next = count_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (play_go)
                begin
                    k_next     = id_idx;
                    state_next = S_PLAYW;
                end
                else if (tick_go)
                begin
                    k_next     = '0;
                    count_next = '0;
                    state_next = S_SCAN;
                end
            end
            S_PLAYW:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (voice_active_reg[rd_idx])
                begin
                    count_next = count_reg + 6'd1;
                    state_next = S_MULL;
                end
                else if (last_k)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_MULL:
            begin
                state_next = S_MULR;
            end
            S_MULR:
            begin
                if (last_k)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_FLUSH:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            count_reg <= count_next;
            done_reg  <= (state_reg == S_FIN);
        end
    end

    // latch the mixed frame as the tick finishes
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN)
        begin
            out_left_reg      <= mac_left;
            out_right_reg     <= mac_right;
            active_voices_reg <= count_reg;
        end
    end

    // slot lengths, voice flags and positions clear at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_active_reg <= '0;
            for (int i = 0; i < NUM_SOUNDS; i++)
            begin
                sound_length_reg[i] <= '0;
                voice_pos_reg[i]    <= '0;
            end
        end
        else
        begin
            if (accept && (opcode == svm_pkg::OP_DEFINE) && id_ok)
            begin
                sound_length_reg[rd_idx] <= length;
            end
            if (play_go)
            begin
                voice_active_reg[rd_idx] <= 1'b1;
                voice_pos_reg[rd_idx]    <= '0;
            end
            else if (ram_re)
            begin
                voice_pos_reg[rd_idx] <= pos_inc;
                if (voice_stop)
                begin
                    voice_active_reg[rd_idx] <= 1'b0;
                end
            end
        end
    end

    // slot starts and weights need no reset
    always_ff @(posedge clk)
    begin
        if (accept && (opcode == svm_pkg::OP_DEFINE) && id_ok)
        begin
            sound_start_reg[rd_idx] <= address;
        end
        if (state_reg == S_PLAYW)
        begin
            voice_weight_reg[k_reg] <= mac_product[svm_pkg::B_W-1:0];
        end
    end

    assign done          = done_reg;
    assign out_left      = out_left_reg;
    assign out_right     = out_right_reg;
    assign active_voices = active_voices_reg;

`ifndef SYNTH
    // a result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // a result only follows the saturate step
    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_FIN))
        else $error("done without a finished tick");

    // a tick always makes the block busy until its frame is out
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == svm_pkg::OP_TICK)) |=> busy)
        else $error("tick taken without going busy");

    // at the end of a tick the voice count does not exceed the number of slots
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> (32'(count_reg) <= NUM_SOUNDS))
        else $error("more voices counted than slots");
`endif

endmodule
`default_nettype wire

FILE: sim/mixer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mixer_checker: result checker for the stereo voice mixer
// Watches the command and result channels, keeps its own copy of the slot
// table, voice state and sample store, predicts every mixed frame and compares
// each result word with the oldest prediction.
// ----------------------------------------------------------------------------
module mixer_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [1:0]         opcode,
    input  wire logic [4:0]         sound_id,
    input  wire logic [15:0]        address,
    input  wire logic [16:0]        length,
    input  wire logic signed [15:0] sample_left,
    input  wire logic signed [15:0] sample_right,
    input  wire logic [15:0]        volume,
    input  wire logic               done,
    input  wire logic signed [15:0] out_left,
    input  wire logic signed [15:0] out_right,
    input  wire logic [5:0]         active_voices,
    output int                      fail_count,
    output int                      frames_pending,
    output int                      frames_checked
);

    localparam int          SLOTS       = 32;
    localparam int          DEPTH       = 65536;
    localparam longint      MIX_GAIN    = 23167;     // 0.707 in Q15
    localparam logic [15:0] FULL_VOLUME = 16'd32768; // 1.0 in Q1.15

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [5:0]         voices;
    } mixed_frame_t;

    logic [15:0]  slot_start  [SLOTS];
    logic [16:0]  slot_length [SLOTS];
    bit           voice_on    [SLOTS];
    logic [16:0]  voice_pos   [SLOTS];
    logic [15:0]  voice_gain  [SLOTS];
    logic [31:0]  frame_store [DEPTH];
    mixed_frame_t expected_frames [$];

    initial
    begin
        fail_count     = 0;
        frames_pending = 0;
        frames_checked = 0;
    end

    task automatic report_error(input string msg);
        $display("[%0t] MIX ERROR: %s", $realtime, msg);
        fail_count++;
    endtask

    // truncate the 2^-30 accumulator towards zero, then clip to 16 bits
    function automatic logic signed [15:0] clip_to_pcm(input longint acc);
        longint mag;
        if (acc < 0)
        begin
            mag = (-acc) >> 30;
            if (mag > 32768)
                return 16'sh8000;
            return 16'(-mag);
        end
        mag = acc >> 30;
        if (mag > 32767)
            return 16'sh7FFF;
        return 16'(mag);
    endfunction

    // mix one frame from every active voice and advance those voices
    function automatic mixed_frame_t mix_frame();
        longint             sum_left;
        longint             sum_right;
        longint             weight;
        logic [15:0]        idx;
        logic signed [15:0] pcm_left;
        logic signed [15:0] pcm_right;
        int                 voices;
        mixed_frame_t       res;
        sum_left  = 0;
        sum_right = 0;
        voices    = 0;
        for (int k = 0; k < SLOTS; k++)
        begin
            if (voice_on[k])
            begin
                idx       = slot_start[k] + voice_pos[k][15:0];
                pcm_left  = frame_store[idx][15:0];
                pcm_right = frame_store[idx][31:16];
                weight    = longint'(voice_gain[k]) * MIX_GAIN;
                sum_left  += longint'(pcm_left) * weight;
                sum_right += longint'(pcm_right) * weight;
                voices++;
                voice_pos[k] = voice_pos[k] + 17'd1;
                if (voice_pos[k] >= slot_length[k] || voice_pos[k] == '0)
                    voice_on[k] = 1'b0;
            end
        end
        res.left   = clip_to_pcm(sum_left);
        res.right  = clip_to_pcm(sum_right);
        res.voices = 6'(voices);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        mixed_frame_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                slot_length[k] = '0;
                voice_on[k]    = 1'b0;
                voice_pos[k]   = '0;
                voice_gain[k]  = '0;
            end
            expected_frames.delete();
        end
        else
        begin
            // retire a result word before taking a new command word
            if (done)
            begin
                if (expected_frames.size() == 0)
                begin
                    report_error($sformatf("result with no tick outstanding: %0d %0d %0d",
                                           out_left, out_right, active_voices));
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (out_left !== want.left)
                        report_error($sformatf("frame %0d out_left %0d, want %0d",
                                               frames_checked, out_left, want.left));
                    if (out_right !== want.right)
                        report_error($sformatf("frame %0d out_right %0d, want %0d",
                                               frames_checked, out_right, want.right));
                    if (active_voices !== want.voices)
                        report_error($sformatf("frame %0d active_voices %0d, want %0d",
                                               frames_checked, active_voices, want.voices));
                    frames_checked++;
                end
            end
            if (start && !busy)
            begin
                case (opcode)
                    svm_pkg::OP_DEFINE:
                    begin
                        slot_start[sound_id]  = address;
                        slot_length[sound_id] = length;
                    end
                    svm_pkg::OP_WRITE: frame_store[address] = {sample_right, sample_left};
                    svm_pkg::OP_PLAY:
                    begin
                        if (slot_length[sound_id] != '0)
                        begin
                            voice_on[sound_id]   = 1'b1;
                            voice_pos[sound_id]  = '0;
                            voice_gain[sound_id] = (volume > FULL_VOLUME) ? FULL_VOLUME
                                                                          : volume;
                        end
                    end
                    svm_pkg::OP_TICK:
                    begin
                        want            = mix_frame();
                        expected_frames = {expected_frames, want};
                    end
                    default: ;
                endcase
            end
        end
        frames_pending = expected_frames.size();
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the stereo voice mixer
// Drives a short directed run over the corner cases, then random sound
// sequences (load frames, define, play, tick) mixed with stray words, with
// random gaps on the command side. The checker beside the block predicts and
// compares every mixed frame.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_WORDS = 1200;  // rough size of the random part
    localparam int SPAN         = 16;    // frames loaded per sound region
    localparam int MAX_REGIONS  = 48;    // regions kept for reuse
    localparam int DRAIN_CYCLES = 120;   // above the longest tick
    localparam int DRAIN_LIMIT  = 5000;
    localparam int QUIET_FROM   = 500;   // word range with no gaps at all
    localparam int QUIET_TO     = 800;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               start        = 1'b0;
    logic [1:0]         opcode       = '0;
    logic [4:0]         sound_id     = '0;
    logic [15:0]        address      = '0;
    logic [16:0]        length       = '0;
    logic signed [15:0] sample_left  = '0;
    logic signed [15:0] sample_right = '0;
    logic [15:0]        volume       = '0;
    logic               busy;
    logic               done;
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic [5:0]         active_voices;

    int fail_count;
    int frames_pending;
    int frames_checked;

    int          words_sent = 0;
    int          words_by_op [4] = '{0, 0, 0, 0};
    logic [15:0] loaded_bases [$];   // starts of regions with SPAN frames written
    int          regions_loaded = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    stereo_voice_mixer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .sound_id      (sound_id),
        .address       (address),
        .length        (length),
        .sample_left   (sample_left),
        .sample_right  (sample_right),
        .volume        (volume),
        .done          (done),
        .out_left      (out_left),
        .out_right     (out_right),
        .active_voices (active_voices)
    );

    mixer_checker watcher (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .sound_id       (sound_id),
        .address        (address),
        .length         (length),
        .sample_left    (sample_left),
        .sample_right   (sample_right),
        .volume         (volume),
        .done           (done),
        .out_left       (out_left),
        .out_right      (out_right),
        .active_voices  (active_voices),
        .fail_count     (fail_count),
        .frames_pending (frames_pending),
        .frames_checked (frames_checked)
    );

    // Present one command word and hold it until the block takes it. Entered
    // and left at a rising edge; the word is taken at the edge on return.
    task automatic send_word(input svm_pkg::op_t op, input logic [4:0] id,
                             input logic [15:0] addr,
                             input logic [16:0] len, input logic [15:0] left,
                             input logic [15:0] right, input logic [15:0] vol);
        // idle the command side now and then, outside the quiet stretch
        while ((words_sent < QUIET_FROM || words_sent >= QUIET_TO)
               && $urandom_range(0, 99) < 29)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        opcode       <= op;
        sound_id     <= id;
        address      <= addr;
        length       <= len;
        sample_left  <= left;
        sample_right <= right;
        volume       <= vol;
        // busy is settled by the falling edge, so sample it there
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        words_sent++;
        words_by_op[op]++;
    endtask

    // Fields that an opcode does not use carry random junk throughout.
    task automatic write_frame(input logic [15:0] addr, input logic [15:0] left,
                               input logic [15:0] right);
        send_word(svm_pkg::OP_WRITE, 5'($urandom), addr, 17'($urandom_range(0, 65536)),
                  left, right, 16'($urandom));
    endtask

    task automatic define_sound(input logic [4:0] id, input logic [15:0] first,
                                input logic [16:0] len);
        send_word(svm_pkg::OP_DEFINE, id, first, len, 16'($urandom), 16'($urandom),
                  16'($urandom));
    endtask

    task automatic play_sound(input logic [4:0] id, input logic [15:0] vol);
        send_word(svm_pkg::OP_PLAY, id, 16'($urandom), 17'($urandom_range(0, 65536)),
                  16'($urandom), 16'($urandom), vol);
    endtask

    task automatic tick_frame();
        send_word(svm_pkg::OP_TICK, 5'($urandom), 16'($urandom),
                  17'($urandom_range(0, 65536)),
                  16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // loud samples swing full scale and clip the mix; quiet ones keep it linear
    function automatic logic [15:0] pcm_value(input bit loud);
        if (loud)
            return 16'($urandom);
        return 16'($urandom_range(0, 4000) - 2000);
    endfunction

    // half the time from the full 16-bit range so the volume clamp is exercised
    function automatic logic [15:0] play_volume();
        if ($urandom_range(0, 1) == 1)
            return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, 32768));
    endfunction

    // mostly non-zero, never beyond the loaded span
    function automatic logic [16:0] sound_frames();
        if ($urandom_range(0, 15) == 0)
            return '0;
        return 17'($urandom_range(1, SPAN));
    endfunction

    function automatic logic [15:0] pick_region();
        return loaded_bases[$urandom_range(0, loaded_bases.size() - 1)];
    endfunction

    initial
    begin : stimulus
        logic [15:0] base;
        logic [4:0]  id;
        bit          loud;
        int          roll;
        int          voices;
        int          drain;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed corner cases ----------------
        // Nothing playing: the mix is silent.
        tick_frame();
        // Frames either side of the address wrap, full scale at FFFF and 0000.
        write_frame(16'hFFFF, 16'h7FFF, 16'h8000);
        write_frame(16'h0000, 16'h8000, 16'h7FFF);
        write_frame(16'h0001, 16'hFFFF, 16'h0001);
        write_frame(16'h0002, 16'h5555, 16'hAAAA);
        // Slot 31 wraps through the end of the store; volume clamps to 1.0.
        define_sound(5'd31, 16'hFFFF, 17'd3);
        play_sound(5'd31, 16'hFFFF);
        // Slot 0 as long as the whole store, played at exactly 1.0.
        define_sound(5'd0, 16'hFFFF, 17'h10000);
        play_sound(5'd0, 16'd32768);
        // Play of a slot never defined, and of a zero-length slot: both dropped.
        play_sound(5'd5, 16'd1000);
        define_sound(5'd1, 16'h0000, 17'd0);
        play_sound(5'd1, 16'd20000);
        // A voice at zero volume still counts as active.
        define_sound(5'd2, 16'h0001, 17'd2);
        play_sound(5'd2, 16'h0000);
        // Long length on a slot left idle, then cleared again.
        define_sound(5'd3, 16'hFFFF, 17'h0FFFF);
        define_sound(5'd3, 16'h0000, 17'd0);
        // Three voices, two of them at full scale: both channels clip.
        tick_frame();
        tick_frame();
        // Restart slot 31 while it plays.
        play_sound(5'd31, 16'd16384);
        tick_frame();
        // Shorten slot 0 under its position: it plays one more frame and stops.
        define_sound(5'd0, 16'hFFFF, 17'd2);
        tick_frame();
        tick_frame();
        tick_frame();

        // ---------------- random sound sequences ----------------
        while (words_sent < RANDOM_WORDS + 24)
        begin
            roll = $urandom_range(0, 99);
            if (loaded_bases.size() == 0 || roll < 25)
            begin
                // load a fresh region, often straddling the wrap
                if ($urandom_range(0, 1) == 1)
                    base = 16'hFFF0 + 16'($urandom_range(0, 15));
                else
                    base = 16'($urandom);
                loud = ($urandom_range(0, 2) == 0);
                for (int i = 0; i < SPAN; i++)
                    write_frame(base + 16'(i), pcm_value(loud), pcm_value(loud));
                loaded_bases = {loaded_bases, base};
                regions_loaded++;
                if (loaded_bases.size() > MAX_REGIONS)
                    void'(loaded_bases.pop_front());
            end
            if (roll < 80)
            begin
                // well-formed: define and play a few voices, then let them run
                voices = $urandom_range(1, 4);
                for (int v = 0; v < voices; v++)
                begin
                    id = 5'($urandom);
                    define_sound(id, pick_region(), sound_frames());
                    play_sound(id, play_volume());
                end
                if ($urandom_range(0, 3) == 0)
                    play_sound(5'($urandom), play_volume());
                repeat ($urandom_range(1, 12))
                    tick_frame();
            end
            else
            begin
                // stray word: redefine, replay, overwrite or tick on its own
                case ($urandom_range(0, 3))
                    0: define_sound(5'($urandom), pick_region(), sound_frames());
                    1: play_sound(5'($urandom), play_volume());
                    2: write_frame(16'($urandom), pcm_value(1'b1), pcm_value(1'b1));
                    default: tick_frame();
                endcase
            end
        end
        start <= 1'b0;

        // drain: wait for the last frames, then allow one full tick more
        drain = 0;
        @(negedge clk);
        while (frames_pending != 0 && drain < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (frames_pending != 0)
            $display("%0d mixed frames never arrived", frames_pending);
        $display("Covered %0d words: %0d defines, %0d writes, %0d plays, %0d ticks.",
                 words_sent, words_by_op[svm_pkg::OP_DEFINE],
                 words_by_op[svm_pkg::OP_WRITE],
                 words_by_op[svm_pkg::OP_PLAY], words_by_op[svm_pkg::OP_TICK]);
        $display("Compared %0d mixed frames over %0d loaded sound regions.",
                 frames_checked, regions_loaded);
        if (fail_count == 0 && frames_pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // hard stop: 8 ms is many times the slowest legal run
    initial
    begin : watchdog
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: stereo_voice_mixer.f
hdl/svm_pkg.sv
hdl/svm_sample_ram.sv
hdl/svm_mac.sv
hdl/stereo_voice_mixer.sv
sim/mixer_checker.sv
sim/testbench.sv
